[hdl/seti_pkg.sv]
`timescale 1ns / 1ps
package seti_pkg;
   localparam int IN_W  = 27;
   localparam int CNT_W = 12;
   localparam logic [CNT_W-1:0] MAX_ITER_RST = 12'd50;

   typedef struct packed {
      logic signed [IN_W-1:0] c_re;
      logic signed [IN_W-1:0] c_im;
      logic [CNT_W-1:0]       limit;
   } job_type;

   typedef struct packed {
      logic [CNT_W-1:0] iter_count;
      logic             escaped;
   } res_type;
endpackage

[hdl/sextic_escape_time_iterator.sv]
`timescale 1ns / 1ps
// Degree-6 multibrot escape-time iterator.
// req_ channel: one beat carries point c (req_c_re, req_c_im, Q3.24 signed).
// rsp_ channel: one beat per point, rsp_iter_count and rsp_escaped.
// csr_ channel: csr_valid/csr_ready write max_iter; write only while idle.
// A front queue (two entries) takes points while the engine works; the
// engine shares one multiplier over four partial products per complex
// product, four products per iteration.
// Each iteration runs four products on the shared multiplier, each followed
// by an accumulate step, and then the escape test.
// The engine handles one point at a time (pop, iterations, final test and
// result cycle), so it sets the throughput.
// Reset (synchronous, active high) empties the queue, idles the engine and
// sets max_iter to 50. A stalled result holds; the engine then waits in its
// done state and the queue keeps taking points until full.
module sextic_escape_time_iterator
   import seti_pkg::*;
#(
   parameter int ITER_LIMIT = 4095,
   parameter int FRAC_BITS  = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic signed [IN_W-1:0] req_c_re,
   input  logic signed [IN_W-1:0] req_c_im,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [CNT_W-1:0]       rsp_iter_count,
   output logic                   rsp_escaped,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CNT_W-1:0]       csr_max_iter
);
   logic [CNT_W-1:0] max_iter_ff;
   logic             q_valid, q_pop;
   job_type          q_job;
   res_type          res;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) max_iter_ff <= MAX_ITER_RST;
      else if (csr_valid) max_iter_ff <= csr_max_iter;
   end

   seti_front #(.ITER_LIMIT(ITER_LIMIT)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_c_re, .req_c_im,
      .max_iter(max_iter_ff), .q_valid, .q_pop, .q_job
   );

   seti_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_job,
      .rsp_valid, .rsp_stall, .rsp_res(res)
   );

   assign rsp_iter_count = res.iter_count;
   assign rsp_escaped    = res.escaped;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_iter_count))
      else $error("result changed under stall");
   a_esc_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_escaped |-> rsp_iter_count != '0)
      else $error("escape with zero count");
endmodule

[hdl/seti_front.sv]
`timescale 1ns / 1ps
module seti_front
   import seti_pkg::*;
#(
   parameter int ITER_LIMIT = 4095
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic signed [IN_W-1:0] req_c_re,
   input  logic signed [IN_W-1:0] req_c_im,
   input  logic [CNT_W-1:0]       max_iter,
   output logic                   q_valid,
   input  logic                   q_pop,
   output job_type                q_job
);
   // two-entry queue between the request port and the iteration engine
   localparam logic [CNT_W:0] LIM_CAP =
      (ITER_LIMIT > 4095) ? (CNT_W+1)'(4095) : (CNT_W+1)'(ITER_LIMIT);
   job_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   job_type    job;

   always_comb begin
      job.c_re  = req_c_re;
      job.c_im  = req_c_im;
      job.limit = ({1'b0, max_iter} > LIM_CAP) ? LIM_CAP[CNT_W-1:0] : max_iter;
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_job     = mem_ff[rp_ff];
   assign wp_in     = push ? ~wp_ff : wp_ff;
   assign rp_in     = q_pop ? ~rp_ff : rp_ff;
   assign cnt_in    = cnt_ff + {1'b0, push} - {1'b0, q_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= job;
   end
endmodule

[hdl/seti_back.sv]
`timescale 1ns / 1ps
module seti_back
   import seti_pkg::*;
#(
   parameter int FRAC_BITS = 24
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   output logic    q_pop,
   input  job_type q_job,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output res_type rsp_res
);
   // z^6 reaches 64 in magnitude and c adds up to 4, so z needs 8 integer bits
   localparam int ZW = FRAC_BITS + 8;
   localparam int PW = 2 * ZW + 2;
   localparam logic [2:0] S_IDLE = 3'd0, S_TEST = 3'd1, S_MUL = 3'd2,
                          S_ACC = 3'd3, S_DONE = 3'd4;
   localparam logic [1:0] M_Z2 = 2'd0, M_Z3 = 2'd1, M_Z4 = 2'd2, M_Z6 = 2'd3;

   logic [2:0]              st_ff, st_in;
   logic [1:0]              ph_ff, ph_in;
   logic [1:0]              pp_ff, pp_in;     // partial product index
   logic signed [ZW-1:0]    zr_ff, zi_ff, zr_in, zi_in;
   logic signed [ZW-1:0]    z2r_ff, z2i_ff, tr_ff, ti_ff;
   logic signed [ZW-1:0]    cr_ff, ci_ff;
   logic [CNT_W-1:0]        lim_ff, i_ff, i_in;
   logic signed [PW-1:0]    acc_re_ff, acc_im_ff;
   logic                    out_v_ff;
   res_type                 out_ff;
   logic signed [ZW-1:0]    ma, mb, fr, fi;
   logic signed [PW-1:0]    prod;
   logic                    in_ok;
   logic signed [ZW-1:0]    two;

   assign two = ZW'(2) <<< FRAC_BITS;

   // operand selection: a is left factor, b right factor
   always_comb begin
      logic signed [ZW-1:0] ar, ai, br, bi;
      ar = zr_ff; ai = zi_ff; br = zr_ff; bi = zi_ff;
      case (ph_ff)
         M_Z2: begin ar = zr_ff; ai = zi_ff; br = zr_ff; bi = zi_ff; end
         M_Z3: begin ar = z2r_ff; ai = z2i_ff; br = zr_ff; bi = zi_ff; end
         M_Z4: begin ar = zr_ff; ai = zi_ff; br = tr_ff; bi = ti_ff; end
         M_Z6: begin ar = tr_ff; ai = ti_ff; br = z2r_ff; bi = z2i_ff; end
         default: ;
      endcase
      case (pp_ff)
         2'd0: begin ma = ar; mb = br; end
         2'd1: begin ma = ai; mb = bi; end
         2'd2: begin ma = ar; mb = bi; end
         default: begin ma = ai; mb = br; end
      endcase
   end

   assign prod = PW'(ma) * PW'(mb);
   assign fr = ZW'(acc_re_ff >>> FRAC_BITS);
   assign fi = ZW'(acc_im_ff >>> FRAC_BITS);

   // escape test: component range first, then the exact |z|^2 check below
   assign in_ok = !(zr_ff > two || zr_ff < -two || zi_ff > two || zi_ff < -two);

   assign q_pop = (st_ff == S_IDLE) && q_valid;
   assign rsp_valid = out_v_ff;
   assign rsp_res = out_ff;

   always_comb begin
      st_in = st_ff; ph_in = ph_ff; pp_in = pp_ff;
      zr_in = zr_ff; zi_in = zi_ff; i_in = i_ff;
      case (st_ff)
         S_IDLE: if (q_valid) begin
            st_in = S_TEST; zr_in = '0; zi_in = '0; i_in = '0;
         end
         S_TEST: begin
            // the exact |z|^2 test is applied at the state register; here check range/limit
            if (i_ff >= lim_ff || !in_ok) st_in = S_DONE;
            else begin st_in = S_MUL; ph_in = M_Z2; pp_in = 2'd0; end
         end
         S_MUL: begin
            pp_in = pp_ff + 2'd1;
            if (pp_ff == 2'd3) st_in = S_ACC;
         end
         S_ACC: begin
            st_in = S_MUL; pp_in = 2'd0;
            if (ph_ff == M_Z6) begin
               zr_in = fr + cr_ff; zi_in = fi + ci_ff;
               i_in = i_ff + 1'b1; st_in = S_TEST;
            end else ph_in = ph_ff + 2'd1;
         end
         S_DONE: if (!out_v_ff || !rsp_stall) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   logic                 sq_ok;
   // |z|^2 check, exact, computed combinationally from narrow z (range-limited)
   always_comb begin
      logic signed [PW-1:0] s;
      s = PW'(zr_ff) * PW'(zr_ff) + PW'(zi_ff) * PW'(zi_ff);
      sq_ok = (s <= (PW'(4) <<< (2 * FRAC_BITS)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; out_v_ff <= 1'b0;
      end else begin
         st_ff <= (st_ff == S_TEST && !sq_ok && in_ok) ? S_DONE : st_in;
         if (st_ff == S_DONE && (!out_v_ff || !rsp_stall)) out_v_ff <= 1'b1;
         else if (!rsp_stall) out_v_ff <= 1'b0;
      end
      ph_ff <= ph_in; pp_ff <= pp_in;
      zr_ff <= zr_in; zi_ff <= zi_in; i_ff <= i_in;
      if (q_pop) begin
         cr_ff <= ZW'(q_job.c_re); ci_ff <= ZW'(q_job.c_im); lim_ff <= q_job.limit;
      end
      if (st_ff == S_MUL) begin
         case (pp_ff)
            2'd0: acc_re_ff <= prod;
            2'd1: acc_re_ff <= acc_re_ff - prod;
            2'd2: acc_im_ff <= prod;
            default: acc_im_ff <= acc_im_ff + prod;
         endcase
      end
      if (st_ff == S_ACC) begin
         case (ph_ff)
            M_Z2: begin z2r_ff <= fr; z2i_ff <= fi; end
            M_Z3, M_Z4: begin tr_ff <= fr; ti_ff <= fi; end
            default: ;
         endcase
      end
      if (st_ff == S_DONE && (!out_v_ff || !rsp_stall)) begin
         out_ff.iter_count <= i_ff;
         out_ff.escaped    <= (i_ff != lim_ff);
      end
   end
endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
   import seti_pkg::*;

   localparam int FRAC = 24;
   localparam logic signed [IN_W-1:0] C_MIN = -27'sd67108863 - 27'sd1;
   localparam logic signed [IN_W-1:0] C_MAX = 27'sd67108863;
   localparam logic signed [IN_W-1:0] ONE   = 27'sd16777216;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic signed [IN_W-1:0] req_c_re = '0;
   logic signed [IN_W-1:0] req_c_im = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [CNT_W-1:0]       rsp_iter_count;
   logic                   rsp_escaped;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CNT_W-1:0]       csr_max_iter = '0;

   res_type          expected_counts[$];
   logic [CNT_W-1:0] cur_limit = MAX_ITER_RST;
   int               errors = 0;
   int               points_sent = 0;
   int               results_seen = 0;
   int               hold_left = 0;
   bit               quiet = 1'b0;

   sextic_escape_time_iterator u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_c_re(req_c_re), .req_c_im(req_c_im),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_iter_count(rsp_iter_count), .rsp_escaped(rsp_escaped),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_max_iter(csr_max_iter)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void cmul(input longint ar, input longint ai, input longint br,
                                input longint bi, output longint rr, output longint ri);
      // arithmetic shift of a signed value floors
      rr = (ar * br - ai * bi) >>> FRAC;
      ri = (ar * bi + ai * br) >>> FRAC;
   endfunction

   function automatic bit in_disk(input longint zr, input longint zi);
      longint two;
      two = longint'(2) <<< FRAC;
      if (zr > two || zr < -two || zi > two || zi < -two) return 1'b0;
      return (zr * zr + zi * zi) <= (longint'(4) <<< (2 * FRAC));
   endfunction

   function automatic res_type predict_escape(input logic signed [IN_W-1:0] cre,
                                              input logic signed [IN_W-1:0] cim,
                                              input logic [CNT_W-1:0] lim);
      res_type r;
      longint zr, zi, r2, i2, r3, i3, r4, i4, r6, i6;
      int n;
      zr = 0;
      zi = 0;
      n = 0;
      while (n < int'(lim) && in_disk(zr, zi)) begin
         cmul(zr, zi, zr, zi, r2, i2);
         cmul(r2, i2, zr, zi, r3, i3);
         cmul(zr, zi, r3, i3, r4, i4);
         cmul(r4, i4, r2, i2, r6, i6);
         zr = r6 + longint'(cre);
         zi = i6 + longint'(cim);
         n++;
      end
      r.iter_count = n[CNT_W-1:0];
      r.escaped = (n != int'(lim));
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
      errors++;
   endtask

   // result checker
   always @(posedge clock) begin
      res_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_counts.size() == 0) begin
            report_mismatch("unexpected result beat", int'(rsp_iter_count), -1);
         end else begin
            e = expected_counts.pop_front();
            if (rsp_iter_count !== e.iter_count)
               report_mismatch("iter_count", int'(rsp_iter_count), int'(e.iter_count));
            if (rsp_escaped !== e.escaped)
               report_mismatch("escaped", int'(rsp_escaped), int'(e.escaped));
         end
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 13);
      end
   end

   task automatic send_point(input logic signed [IN_W-1:0] cre,
                             input logic signed [IN_W-1:0] cim);
      res_type e;
      e = predict_escape(cre, cim, cur_limit);
      while (!quiet && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_c_re <= cre;
      req_c_im <= cim;
      do @(posedge clock); while (req_stall);
      expected_counts.push_back(e);
      points_sent++;
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_counts.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_limit(input logic [CNT_W-1:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_max_iter <= v;
      do @(posedge clock); while (!csr_ready);
      cur_limit = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [IN_W-1:0] rand_coord;
      case ($urandom_range(9))
         0, 1, 2, 3, 4: rand_coord = IN_W'($urandom_range(41943040) - 20971520);
         5, 6, 7:       rand_coord = IN_W'($urandom);
         8:             rand_coord = $urandom_range(1) ? C_MIN : C_MAX;
         default:       rand_coord = IN_W'(($urandom_range(1) ? ONE : -ONE)
                                     + ($urandom_range(2000000) - 1000000));
      endcase
   endfunction

   task automatic test_reset_limit;
      // default limit of 50 straight after reset
      send_point('0, '0);
      send_point(C_MIN, C_MIN);
      send_point(C_MAX, C_MAX);
      send_point(C_MIN, C_MAX);
      send_point(C_MAX, '0);
      send_point(IN_W'(2 * ONE), '0);      // lands exactly on the circle, escapes next
      send_point('0, IN_W'(2 * ONE));
      send_point(IN_W'(2 * ONE + 1), '0);  // component just beyond 2
      send_point(-ONE, '0);
      send_point(ONE, '0);
      send_point(-27'sd1, -27'sd1);
      send_point(27'sd13421772, 27'sd5000000);
   endtask

   task automatic test_limit_zero;
      write_limit(12'd0);
      send_point('0, '0);
      send_point(C_MAX, C_MIN);
   endtask

   task automatic test_limit_one;
      write_limit(12'd1);
      send_point('0, '0);
      send_point(C_MAX, C_MAX);   // leaves the disk on the last allowed pass, but counts as not escaped
      send_point(IN_W'(2 * ONE), IN_W'(2 * ONE));
   endtask

   task automatic test_limit_max;
      write_limit(12'd4095);
      send_point('0, '0);
      send_point(ONE, ONE);
      send_point(-27'sd12000000, 27'sd9000000);
   endtask

   task automatic test_backpressure;
      write_limit(12'd8);
      hold_left = 400;
      repeat (10) send_point(rand_coord(), rand_coord());
   endtask

   task automatic test_random;
      int k;
      int chunk;
      for (chunk = 0; chunk < 7; chunk++) begin
         write_limit(chunk == 6 ? 12'd2 : 12'($urandom_range(1, 40)));
         quiet = (chunk == 1);
         for (k = 0; k < 100; k++) send_point(rand_coord(), rand_coord());
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_limit();
      test_limit_zero();
      test_limit_one();
      test_limit_max();
      test_backpressure();
      test_random();
      drain();
      if (expected_counts.size() != 0)
         report_mismatch("results still missing", 0, expected_counts.size());
      $display("covered %0d points, %0d results, limits 0, 1, 50, 4095 and random",
               points_sent, results_seen);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("TB_ERROR");
      $finish;
   end
endmodule
